@@ sv/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// One stored cache entry layout and the status flags of an entry scan.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 64;
  localparam int LIM_W   = 5;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [CNT_W-1:0] CNT_FIRST  = CNT_W'(1);

  // Request kinds carried on in_tuser.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic victim_found;
    logic free_found;
  } scan_flags_t;

endpackage

@@ sv/lfu_store.sv @@
// ----------------------------------------------------------------------------
// lfu_store: entry memory and valid bits
// One write and one registered read per cycle, plus valid set and clear.
// ----------------------------------------------------------------------------
module lfu_store #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  lfu_pkg::entry_t wr_entry,
  input  logic [AW-1:0]  rd_addr,
  output lfu_pkg::entry_t rd_entry,
  output logic           rd_valid,
  input  logic           set_en,
  input  logic [AW-1:0]  set_idx,
  input  logic           clr_en,
  input  logic [AW-1:0]  clr_idx
);
  import lfu_pkg::*;

  entry_t               mem [CAPACITY];
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  entry_t               rd_entry_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  // Clear before set so that a slot evicted and refilled at once stays valid.
  always_comb begin
    valid_nxt = valid_r;
    if (clr_en) begin
      valid_nxt[clr_idx] = 1'b0;
    end
    if (set_en) begin
      valid_nxt[set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

@@ sv/lfu_scan.sv @@
// ----------------------------------------------------------------------------
// lfu_scan: shared compare unit for the entry scan
// Examines one entry per cycle while cmp_en is high, for key match, LFU victim and first free slot.
// ----------------------------------------------------------------------------
module lfu_scan #(
  parameter int AW = 4
) (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       cmp_en,
  input  logic [AW-1:0]              cmp_idx,
  input  lfu_pkg::entry_t            entry,
  input  logic                       entry_valid,
  input  logic [lfu_pkg::KEY_W-1:0]  key,
  output lfu_pkg::scan_flags_t       flags,
  output logic [AW-1:0]              hit_idx,
  output logic [lfu_pkg::VAL_W-1:0]  hit_value,
  output logic [lfu_pkg::CNT_W-1:0]  hit_count,
  output logic [AW-1:0]              victim_idx,
  output logic [AW-1:0]              free_idx
);
  import lfu_pkg::*;

  scan_flags_t        flags_r, flags_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [VAL_W-1:0]   hit_value_r, hit_value_nxt;
  logic [CNT_W-1:0]   hit_count_r, hit_count_nxt;
  logic [AW-1:0]      victim_idx_r, victim_idx_nxt;
  logic [CNT_W-1:0]   victim_count_r, victim_count_nxt;
  logic [STAMP_W-1:0] victim_stamp_r, victim_stamp_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic               better;

  // Lower count wins; on equal counts the older stamp wins.
  assign better = !flags_r.victim_found || (entry.count < victim_count_r) ||
                  ((entry.count == victim_count_r) && (entry.stamp < victim_stamp_r));

  always_comb begin
    flags_nxt        = flags_r;
    hit_idx_nxt      = hit_idx_r;
    hit_value_nxt    = hit_value_r;
    hit_count_nxt    = hit_count_r;
    victim_idx_nxt   = victim_idx_r;
    victim_count_nxt = victim_count_r;
    victim_stamp_nxt = victim_stamp_r;
    free_idx_nxt     = free_idx_r;
    if (start) begin
      flags_nxt = '0;
    end else if (cmp_en) begin
      if (entry_valid) begin
        if (!flags_r.hit && (entry.key == key)) begin
          flags_nxt.hit = 1'b1;
          hit_idx_nxt   = cmp_idx;
          hit_value_nxt = entry.value;
          hit_count_nxt = entry.count;
        end
        if (better) begin
          flags_nxt.victim_found = 1'b1;
          victim_idx_nxt         = cmp_idx;
          victim_count_nxt       = entry.count;
          victim_stamp_nxt       = entry.stamp;
        end
      end else if (!flags_r.free_found) begin
        flags_nxt.free_found = 1'b1;
        free_idx_nxt         = cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r        <= flags_nxt;
    hit_idx_r      <= hit_idx_nxt;
    hit_value_r    <= hit_value_nxt;
    hit_count_r    <= hit_count_nxt;
    victim_idx_r   <= victim_idx_nxt;
    victim_count_r <= victim_count_nxt;
    victim_stamp_r <= victim_stamp_nxt;
    free_idx_r     <= free_idx_nxt;
  end

  assign flags      = flags_r;
  assign hit_idx    = hit_idx_r;
  assign hit_value  = hit_value_r;
  assign hit_count  = hit_count_r;
  assign victim_idx = victim_idx_r;
  assign free_idx   = free_idx_r;

endmodule

@@ sv/lfu_cache_table.sv @@
// Requests are taken only in the idle state, so no new item is accepted until the
// current one has finished: the accepting cycle, a read of every entry through the
// single entry memory read port, the last compare and the writeback; a held result
// waiting for out_tready stalls the writeback and so delays the next acceptance.
// Reset (synchronous, active low) clears all valid bits, the occupancy, the touch
// clock and the output valid flag, and sets the entry limit to 16.
// ----------------------------------------------------------------------------
// lfu_cache_table: fully associative key-value cache with LFU replacement
// Gets and puts scan every entry through one compare unit; the touched entry, if
// any, is then written back in the same cycle that loads the result register.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: entries_in_use in bits 4:0.
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // lookup_key [31:0], store_value [63:32]
  input  logic        in_tuser,   // action [0]: 0 get, 1 put
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value [31:0]
  output logic        out_tuser   // found [0]
);
  import lfu_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIM_W) ? CW : LIM_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic               cmp_en_r;
  logic [AW-1:0]      cmp_idx_r;
  logic [LIM_W-1:0]   limit_cfg_r;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [STAMP_W-1:0] touch_r, touch_nxt;

  // Request held for the whole scan.
  logic               act_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;

  // Result register; it parts the two sides of the block.
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;

  logic               in_fire;
  logic               out_free;
  logic               finish;
  logic [AW-1:0]      rd_addr;

  entry_t             rd_entry;
  logic               rd_valid;
  scan_flags_t        flags;
  logic [AW-1:0]      hit_idx;
  logic [VAL_W-1:0]   hit_value;
  logic [CNT_W-1:0]   hit_count;
  logic [AW-1:0]      victim_idx;
  logic [AW-1:0]      free_idx;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_entry;
  logic               set_en;
  logic               clr_en;

  logic [LW-1:0]      limit;
  logic               table_full;
  logic               evict;
  logic [AW-1:0]      ins_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == ST_DECIDE) && out_free;
  assign rd_addr   = issue_cnt_r[AW-1:0];

  // Effective limit: zero acts as one, anything past the capacity as the capacity.
  always_comb begin
    limit = LW'(limit_cfg_r);
    if (limit_cfg_r == '0) begin
      limit = LW'(1);
    end
    if (limit > LW'(CAPACITY)) begin
      limit = LW'(CAPACITY);
    end
  end

  assign table_full = LW'(occ_r) >= limit;
  // A full table always holds a valid entry, so the victim is known here.
  assign evict      = table_full && flags.victim_found;
  // After evicting, the lowest free slot is the earlier of the first free
  // slot seen by the scan and the victim itself.
  always_comb begin
    ins_idx = free_idx;
    if (evict && (!flags.free_found || (victim_idx < free_idx))) begin
      ins_idx = victim_idx;
    end
  end

  // Writeback decision, taken in the cycle that loads the result register.
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = ins_idx;
    wr_entry.key   = key_r;
    wr_entry.value = val_r;
    wr_entry.count = CNT_FIRST;
    wr_entry.stamp = touch_r;
    set_en        = 1'b0;
    clr_en        = 1'b0;
    occ_nxt       = occ_r;
    touch_nxt     = touch_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = flags.hit;
      if (flags.hit) begin
        // Hit: refresh count and stamp, overwrite the value on a put.
        wr_en          = 1'b1;
        wr_addr        = hit_idx;
        wr_entry.value = (act_r == ACT_PUT) ? val_r : hit_value;
        wr_entry.count = (hit_count == CNT_MAX) ? CNT_MAX : hit_count + CNT_FIRST;
        touch_nxt      = touch_r + STAMP_W'(1);
        out_value_nxt  = (act_r == ACT_PUT) ? PUT_VALUE : hit_value;
      end else if (act_r == ACT_PUT) begin
        // Put miss: evict if needed, then insert with a count of one.
        wr_en         = 1'b1;
        set_en        = 1'b1;
        clr_en        = evict;
        touch_nxt     = touch_r + STAMP_W'(1);
        out_value_nxt = PUT_VALUE;
        if (!evict) begin
          occ_nxt = occ_r + CW'(1);
        end
      end else begin
        out_value_nxt = MISS_VALUE;
      end
    end
  end

  // Sequencer: issue CAPACITY reads, let the last compare land, then decide.
  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt     = ST_SCAN;
          issue_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        issue_cnt_nxt = issue_cnt_r + CW'(1);
        if (issue_cnt_r == CW'(CAPACITY - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_cnt_r <= '0;
      cmp_en_r    <= 1'b0;
      limit_cfg_r <= LIM_W'(16);
      occ_r       <= '0;
      touch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      cmp_en_r    <= (state_r == ST_SCAN);
      occ_r       <= occ_nxt;
      touch_r     <= touch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= rd_addr;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
    if (in_fire) begin
      act_r <= in_tuser;
      key_r <= in_tdata[31:0];
      val_r <= in_tdata[63:32];
    end
  end

  lfu_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .set_en   (set_en),
    .set_idx  (ins_idx),
    .clr_en   (clr_en),
    .clr_idx  (victim_idx)
  );

  lfu_scan #(
    .AW (AW)
  ) u_scan (
    .clk         (clk),
    .start       (in_fire),
    .cmp_en      (cmp_en_r),
    .cmp_idx     (cmp_idx_r),
    .entry       (rd_entry),
    .entry_valid (rd_valid),
    .key         (key_r),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .hit_value   (hit_value),
    .hit_count   (hit_count),
    .victim_idx  (victim_idx),
    .free_idx    (free_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_found_r;

endmodule
